// ===== rtl/core/lhlr_pkg.sv =====
// Shared constants for the luminance replacement core.
`timescale 1ns / 1ps
package lhlr_pkg;
  // Default sample width, Q0.S fractions.
  localparam int unsigned SAMPLE_BITS_DEF = 16;
endpackage

// ===== rtl/core/lrgb_hsl_luminance_replace_core.sv =====
// Top level of the LRGB luminance replacement pixel pipeline.
`timescale 1ns / 1ps
// Takes one pixel request per cycle (red, green, blue, luminance, H-alpha, all
// unsigned Q0.S) and returns one result per request in order: the pixel is
// taken to hue/saturation/lightness, its lightness is replaced by the
// luminance sample, it is taken back to RGB, and H-alpha is added to red when
// halpha_enable is set. Sustained rate is one pixel per cycle while results are
// taken; the pipeline is the front stage, the two parallel restoring dividers
// (saturation and hue) that resolve one quotient bit per stage, and four
// recombine stages. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall on the result side holds every
// stage and loses nothing. Write halpha_enable only while no request is in
// flight.
module lrgb_hsl_luminance_replace_core
  import lhlr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // red_in, green_in, blue_in, luminance_in, halpha_in (S bits each), zero pad
  input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // red_out (S+1 bits), green_out (S), blue_out (S), zero pad
  output logic [((3*SAMPLE_BITS+8)/8)*8-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);
  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned IW = ((5*SAMPLE_BITS+7)/8)*8;
  localparam int unsigned OW = ((3*SAMPLE_BITS+8)/8)*8;
  localparam int unsigned PW = 2*SAMPLE_BITS;

  logic         halpha_en_r;
  logic         en;
  logic         f_valid, d_valid, h_valid, b_valid;
  logic [S:0]   sat_num, sat_den, sat_q, hue_q;
  logic [S+2:0] hue_num, hue_den;
  logic [PW-1:0] f_pay, d_pay;
  logic         h_pay;
  logic [S:0]   red_o;
  logic [S-1:0] green_o, blue_o;

  // global advance: output register empty or being taken
  assign en        = !b_valid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halpha_en_r <= 1'b0;
    end else if (cfg_valid) begin
      halpha_en_r <= cfg_data;
    end
  end

  lhlr_front #(.SAMPLE_BITS(S)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .red       (in_tdata[S-1:0]),
    .green     (in_tdata[2*S-1:S]),
    .blue      (in_tdata[3*S-1:2*S]),
    .out_valid (f_valid),
    .sat_num   (sat_num),
    .sat_den   (sat_den),
    .hue_num   (hue_num),
    .hue_den   (hue_den)
  );

  // luminance and H-alpha ride alongside, delayed to match the front stage
  logic [PW-1:0] pay_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pay_r <= in_tdata[5*S-1:3*S];
    end
  end
  assign f_pay = pay_r;

  lhlr_div #(.SAMPLE_BITS(S), .DW(S+1), .PW(PW)) u_div_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .num       (sat_num),
    .den       (sat_den),
    .pay_in    (f_pay),
    .out_valid (d_valid),
    .quo       (sat_q),
    .pay_out   (d_pay)
  );

  lhlr_div #(.SAMPLE_BITS(S), .DW(S+3), .PW(1)) u_div_hue (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .num       (hue_num),
    .den       (hue_den),
    .pay_in    (f_valid),
    .out_valid (h_valid),
    .quo       (hue_q),
    .pay_out   (h_pay)
  );

  lhlr_back #(.SAMPLE_BITS(S)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .halpha_en (halpha_en_r),
    .in_valid  (d_valid && h_valid),
    .sat       (sat_q),
    .hue_q     (hue_q),
    .lum       (d_pay[S-1:0]),
    .halpha    (d_pay[2*S-1:S]),
    .out_valid (b_valid),
    .red       (red_o),
    .green     (green_o),
    .blue      (blue_o)
  );

  assign out_tvalid = b_valid;
  assign out_tdata  = OW'({blue_o, green_o, red_o});

  logic unused_in;
  assign unused_in = ^{h_pay, IW'(in_tdata) >> (5*S)};
endmodule

// ===== rtl/core/lhlr_front.sv =====
// Front stage: max, min, chroma, saturation and hue dividend/divisor setup.
`timescale 1ns / 1ps
module lhlr_front
  import lhlr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [SAMPLE_BITS-1:0]   red,
  input  logic [SAMPLE_BITS-1:0]   green,
  input  logic [SAMPLE_BITS-1:0]   blue,
  output logic                     out_valid,
  output logic [SAMPLE_BITS:0]     sat_num,
  output logic [SAMPLE_BITS:0]     sat_den,
  output logic [SAMPLE_BITS+2:0]   hue_num,
  output logic [SAMPLE_BITS+2:0]   hue_den
);
  localparam int unsigned S = SAMPLE_BITS;
  localparam logic [S+1:0] ONE = (S+2)'(1) << S;

  logic [S-1:0] vmax, vmin, chroma;
  logic [S+1:0] vsum, sden;
  logic [S+2:0] d3, n;
  logic         live;
  logic         valid_r;
  logic [S:0]   sat_num_r, sat_den_r;
  logic [S+2:0] hue_num_r, hue_den_r;

  always_comb begin
    vmax = red;
    if (green > vmax) vmax = green;
    if (blue > vmax) vmax = blue;
    vmin = red;
    if (green < vmin) vmin = green;
    if (blue < vmin) vmin = blue;
    chroma = vmax - vmin;
    live = (vmax != '0) && (chroma != '0);
    vsum = (S+2)'(vmax) + (S+2)'(vmin);
    sden = (vsum <= ONE) ? vsum : (ONE << 1) - vsum;
    d3 = (S+3)'(chroma) * (S+3)'(3);
    // sextant numerator, h6 * d
    if (red == vmax) begin
      n = (green == vmin) ? (S+3)'(chroma) * (S+3)'(5) + (S+3)'(vmax - blue)
                          : (S+3)'(green - vmin);
    end else if (green == vmax) begin
      n = (blue == vmin) ? (S+3)'(chroma) + (S+3)'(vmax - red)
                         : d3 - (S+3)'(vmax - blue);
    end else begin
      n = (red == vmin) ? d3 + (S+3)'(vmax - green)
                        : (S+3)'(chroma) * (S+3)'(5) - (S+3)'(vmax - red);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (live) begin
        sat_num_r <= (S+1)'(chroma);
        sat_den_r <= sden[S:0];
        hue_num_r <= n;
        hue_den_r <= d3 << 1;
      end else begin
        // grey or black: zero over one gives zero hue and saturation
        sat_num_r <= '0;
        sat_den_r <= (S+1)'(1);
        hue_num_r <= '0;
        hue_den_r <= (S+3)'(1);
      end
    end
  end

  assign out_valid = valid_r;
  assign sat_num   = sat_num_r;
  assign sat_den   = sat_den_r;
  assign hue_num   = hue_num_r;
  assign hue_den   = hue_den_r;
endmodule

// ===== rtl/core/lhlr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, (num << S) / den.
`timescale 1ns / 1ps
module lhlr_div
  import lhlr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned DW = SAMPLE_BITS + 1,
  parameter int unsigned PW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DW-1:0]          num,   // must not exceed den
  input  logic [DW-1:0]          den,
  input  logic [PW-1:0]          pay_in,
  output logic                   out_valid,
  output logic [SAMPLE_BITS:0]   quo,
  output logic [PW-1:0]          pay_out
);
  localparam int unsigned S = SAMPLE_BITS;

  logic [DW-1:0] rem_r [0:S];
  logic [DW-1:0] den_r [0:S];
  logic [S:0]    quo_r [0:S];
  logic [PW-1:0] pay_r [0:S];
  logic [S:0]    vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[S-1:0], in_valid};
    end
  end

  // top bit: quotient is at most one
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (num >= den) ? num - den : num;
      den_r[0] <= den;
      quo_r[0] <= (S+1)'(num >= den);
      pay_r[0] <= pay_in;
    end
  end

  for (genvar k = 1; k <= S; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1], 1'b0};
    assign ge    = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(trial - {1'b0, den_r[k-1]}) : trial[DW-1:0];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= {quo_r[k-1][S-1:0], ge};
        pay_r[k] <= pay_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[S];
  assign quo       = quo_r[S];
  assign pay_out   = pay_r[S];
endmodule

// ===== rtl/core/lhlr_back.sv =====
// Back end: HSL to RGB with replaced lightness, saturation and H-alpha add.
`timescale 1ns / 1ps
module lhlr_back
  import lhlr_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   halpha_en,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS:0]   sat,
  input  logic [SAMPLE_BITS:0]   hue_q,
  input  logic [SAMPLE_BITS-1:0] lum,
  input  logic [SAMPLE_BITS-1:0] halpha,
  output logic                   out_valid,
  output logic [SAMPLE_BITS:0]   red,
  output logic [SAMPLE_BITS-1:0] green,
  output logic [SAMPLE_BITS-1:0] blue
);
  localparam int unsigned S = SAMPLE_BITS;
  localparam logic [2:0] SEXT_RY = 3'd0;
  localparam logic [2:0] SEXT_YG = 3'd1;
  localparam logic [2:0] SEXT_GC = 3'd2;
  localparam logic [2:0] SEXT_CB = 3'd3;
  localparam logic [2:0] SEXT_BM = 3'd4;
  localparam logic [S-1:0] HALF = S'(1) << (S-1);

  logic [3:0] vld_r;

  // stage P: p = l * s
  logic [S-1:0]   p_l_r, p_ha_r, p_hue_r;
  logic [S:0]     p_s_r, p_p_r, p_p_nxt;
  logic [2*S:0]   prod_ls;
  // stage V: vv, mm, sextant split
  logic [S+1:0]   v_vv_r, v_mm_r, vv_nxt, mm_nxt;
  logic signed [S+2:0] mm_raw;
  logic [S+2:0]   t6;
  logic [2:0]     v_sext_r;
  logic [S-1:0]   v_fract_r, v_l_r, v_ha_r;
  // stage W: w = (vv - mm) * fract
  logic [2*S+1:0] prod_w;
  logic [S+1:0]   w_w_r, w_vv_r, w_mm_r;
  logic [2:0]     w_sext_r;
  logic [S-1:0]   w_l_r, w_ha_r;
  // stage O
  logic [S+1:0]   mid1, mid2, rsel, gsel, bsel;
  logic [S-1:0]   rsat, gsat, bsat;
  logic [S:0]     red_r;
  logic [S-1:0]   green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  assign prod_ls = (2*S+1)'(lum) * (2*S+1)'(sat);
  assign p_p_nxt = prod_ls[2*S:S];

  always_ff @(posedge clk) begin
    if (en) begin
      p_l_r   <= lum;
      p_ha_r  <= halpha;
      p_s_r   <= sat;
      p_p_r   <= p_p_nxt;
      // a hue of exactly one wraps to zero
      p_hue_r <= hue_q[S] ? '0 : hue_q[S-1:0];
    end
  end

  always_comb begin
    if (p_l_r <= HALF) vv_nxt = (S+2)'(p_l_r) + (S+2)'(p_p_r);
    else vv_nxt = (S+2)'(p_l_r) + (S+2)'(p_s_r) - (S+2)'(p_p_r);
    mm_raw = $signed({2'b00, p_l_r, 1'b0}) - $signed({1'b0, vv_nxt});
    if (mm_raw < 0) mm_nxt = '0;
    else if (mm_raw > $signed({1'b0, vv_nxt})) mm_nxt = vv_nxt;
    else mm_nxt = mm_raw[S+1:0];
    t6 = (S+3)'(p_hue_r) * (S+3)'(6);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_vv_r    <= vv_nxt;
      v_mm_r    <= mm_nxt;
      v_sext_r  <= t6[S+2:S];
      v_fract_r <= t6[S-1:0];
      v_l_r     <= p_l_r;
      v_ha_r    <= p_ha_r;
    end
  end

  assign prod_w = (2*S+2)'(v_vv_r - v_mm_r) * (2*S+2)'(v_fract_r);

  always_ff @(posedge clk) begin
    if (en) begin
      w_w_r    <= prod_w[2*S+1:S];
      w_vv_r   <= v_vv_r;
      w_mm_r   <= v_mm_r;
      w_sext_r <= v_sext_r;
      w_l_r    <= v_l_r;
      w_ha_r   <= v_ha_r;
    end
  end

  always_comb begin
    mid1 = w_mm_r + w_w_r;
    mid2 = w_vv_r - w_w_r;
    case (w_sext_r)
      SEXT_RY: begin rsel = w_vv_r; gsel = mid1;   bsel = w_mm_r; end
      SEXT_YG: begin rsel = mid2;   gsel = w_vv_r; bsel = w_mm_r; end
      SEXT_GC: begin rsel = w_mm_r; gsel = w_vv_r; bsel = mid1;   end
      SEXT_CB: begin rsel = w_mm_r; gsel = mid2;   bsel = w_vv_r; end
      SEXT_BM: begin rsel = mid1;   gsel = w_mm_r; bsel = w_vv_r; end
      default: begin rsel = w_vv_r; gsel = w_mm_r; bsel = mid2;   end
    endcase
    if (w_vv_r == '0) begin
      // zero lightness after replacement: pass luminance straight
      rsat = w_l_r;
      gsat = w_l_r;
      bsat = w_l_r;
    end else begin
      rsat = (rsel[S+1:S] != 2'b00) ? '1 : rsel[S-1:0];
      gsat = (gsel[S+1:S] != 2'b00) ? '1 : gsel[S-1:0];
      bsat = (bsel[S+1:S] != 2'b00) ? '1 : bsel[S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= (S+1)'(rsat) + (halpha_en ? (S+1)'(w_ha_r) : '0);
      green_r <= gsat;
      blue_r  <= bsat;
    end
  end

  assign out_valid = vld_r[3];
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

`ifndef SYNTHESIS
  a_mm_le_vv: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (v_mm_r <= v_vv_r))
    else $error("mm above vv");
  a_sext_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (v_sext_r <= SEXT_BM + 3'd1))
    else $error("sextant out of range");
  a_w_span: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (w_w_r <= w_vv_r - w_mm_r))
    else $error("interpolation exceeds span");
`endif
endmodule

// ===== bench/tb_lrgb_hsl_luminance_replace_core.sv =====
// Self-checking bench for the LRGB luminance replacement pixel pipeline.
`timescale 1ns / 1ps
module tb_lrgb_hsl_luminance_replace_core;
  import lhlr_pkg::*;

  localparam int S = SAMPLE_BITS_DEF;
  localparam int IW = ((5*S+7)/8)*8;
  localparam int OW = ((3*S+8)/8)*8;
  localparam longint ONE = 64'd1 << S;
  localparam longint SMASK = ONE - 1;
  localparam int LATENCY = S + 6;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [S-1:0] halpha;
    logic [S-1:0] lum;
    logic [S-1:0] blue;
    logic [S-1:0] green;
    logic [S-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [S-1:0] blue;
    logic [S-1:0] green;
    logic [S:0]   red;
  } rgb_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OW-1:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_data = 0;

  lrgb_hsl_luminance_replace_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  pixel_t pending_px[$];
  rgb_t   expected_rgb[$];
  bit     halpha_on = 0;
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_cycles = 0;
  int     idle_count = 0;

  function automatic longint clamp_sample(longint x);
    if (x < 0) return 0;
    if (x > SMASK) return SMASK;
    return x;
  endfunction

  // HSL round trip with the lightness swapped for the luminance sample
  function automatic rgb_t recombine(pixel_t px, bit ha_en);
    longint r, g, b, l, v, m, d, sat, hue, den, n, p, vv, mm, t, sext, fr, w, m1, m2;
    longint ro, go, bo;
    rgb_t res;
    r = longint'(px.red); g = longint'(px.green); b = longint'(px.blue);
    l = longint'(px.lum);
    sat = 0; hue = 0;
    v = r; if (g > v) v = g; if (b > v) v = b;
    m = r; if (g < m) m = g; if (b < m) m = b;
    d = v - m;
    if (v > 0 && d > 0) begin
      den = (v + m <= ONE) ? v + m : 2*ONE - v - m;
      sat = (d << S) / den;
      if (r == v) n = (g == m) ? 5*d + (v - b) : (g - m);
      else if (g == v) n = (b == m) ? d + (v - r) : 3*d - (v - b);
      else n = (r == m) ? 3*d + (v - g) : 5*d - (v - r);
      hue = (n << S) / (6*d);
      if (hue >= ONE) hue = 0;  // pure red wraps to sextant 0
    end
    ro = l; go = l; bo = l;
    p = (l * sat) >> S;
    vv = (l <= (ONE >> 1)) ? l + p : l + sat - p;
    if (vv > 0) begin
      mm = 2*l - vv;
      if (mm < 0) mm = 0;
      if (mm > vv) mm = vv;
      t = hue * 6;
      sext = t >> S;
      fr = t & SMASK;
      w = ((vv - mm) * fr) >> S;
      m1 = mm + w; m2 = vv - w;
      case (sext)
        0: begin ro = vv; go = m1; bo = mm; end
        1: begin ro = m2; go = vv; bo = mm; end
        2: begin ro = mm; go = vv; bo = m1; end
        3: begin ro = mm; go = m2; bo = vv; end
        4: begin ro = m1; go = mm; bo = vv; end
        default: begin ro = vv; go = mm; bo = m2; end
      endcase
    end
    res.red = (S+1)'(clamp_sample(ro) + (ha_en ? longint'(px.halpha) : 64'sd0));
    res.green = S'(clamp_sample(go));
    res.blue = S'(clamp_sample(bo));
    return res;
  endfunction

  // Driver: one request in flight on the bus, prediction on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rgb.push_back(recombine(pixel_t'(in_tdata[5*S-1:0]), halpha_on));
        void'(pending_px.pop_front());
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_px.size() > (in_tvalid && in_tready ? 0 : 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1;
          in_tdata <= IW'(pending_px[0]);
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // Monitor: compare against oldest prediction, randomize backpressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        rgb_t got;
        got = rgb_t'(out_tdata[3*S:0]);
        if (expected_rgb.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          if (got !== expected_rgb[0]) begin
            $display("%0t mismatch expected r=%h g=%h b=%h actual r=%h g=%h b=%h", $time,
                     expected_rgb[0].red, expected_rgb[0].green, expected_rgb[0].blue,
                     got.red, got.green, got.blue);
            errors++;
          end
          void'(expected_rgb.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [S-1:0] f[5];
    for (int i = 0; i < 5; i++) begin
      case ($urandom_range(7))
        0: f[i] = '0;
        1: f[i] = S'(SMASK);
        2: f[i] = S'(ONE >> 1);
        default: f[i] = S'($urandom());
      endcase
    end
    px = {f[4], f[3], f[2], f[1], f[0]};
    if ($urandom_range(9) == 0) begin px.green = px.red; px.blue = px.red; end
    else if ($urandom_range(9) == 0) px.green = px.blue;
    return px;
  endfunction

  task automatic drain();
    wait (pending_px.size() == 0 && !in_tvalid);
    wait (expected_rgb.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_enable(bit en);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= en;
    do @(posedge clk); while (!cfg_ready);
    halpha_on = en;
    cfg_valid <= 0;
  endtask

  initial begin
    pixel_t px;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, grey, black, pure red hue wrap, full scale
    for (int en = 0; en < 2; en++) begin
      write_enable(en[0]);
      pending_px.push_back({16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF});
      pending_px.push_back({16'h1234, 16'h8000, 16'h0, 16'h0, 16'h0});
      pending_px.push_back({16'hFFFF, 16'h0, 16'h4000, 16'h4000, 16'h4000});
      pending_px.push_back({16'h0, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      pending_px.push_back({16'hFFFF, 16'h8001, 16'h0, 16'hFFFF, 16'h0});
      pending_px.push_back({16'h5555, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0});
      pending_px.push_back({16'hAAAA, 16'h7FFF, 16'h0, 16'hFFFF, 16'h8000});
      pending_px.push_back({16'h0001, 16'hC000, 16'h1000, 16'h2000, 16'hF000});
      pending_px.push_back({16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0001, 16'h8000});
      pending_px.push_back({16'h8000, 16'h4000, 16'h0, 16'h0, 16'h1});
      pending_px.push_back({16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0});
      drain();
    end
    // random phases over idle patterns and both enable settings
    for (int ph = 0; ph < 8; ph++) begin
      write_enable(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (ph == 4) hold_cycles = 200;  // long hold-off fills the pipe
      for (int i = 0; i < 200; i++) pending_px.push_back(random_pixel());
      drain();  // sender pauses until everything is back
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== lrgb_hsl_luminance_replace_core.f =====
rtl/core/lhlr_pkg.sv
rtl/core/lhlr_front.sv
rtl/core/lhlr_div.sv
rtl/core/lhlr_back.sv
rtl/core/lrgb_hsl_luminance_replace_core.sv
bench/tb_lrgb_hsl_luminance_replace_core.sv
